/* hw/rtl/ctm_pkg.sv */
// Shared types and constants for the coordinate trimmed-mean core.
// Lane count, control sideband struct, register index codes.
// No dependencies.
`timescale 1ns / 1ps

package ctm_pkg;

    // Client lanes carried by one item
    localparam int LANES     = 8;
    localparam int LANE_W    = $clog2(LANES);
    localparam int CNT_W     = $clog2(LANES + 1);

    // Trim fraction, unsigned Q1.8
    localparam int BETA_W    = 9;
    localparam int BETA_FRAC = 8;
    localparam logic [BETA_W-1:0] BETA_ONE = BETA_W'(256);

    // Register file
    localparam int APB_DATA_W  = 32;
    localparam int ADDR_W      = 3;
    localparam int REG_IDX_LSB = 2;
    localparam logic [CNT_W-1:0]  CLIENT_COUNT_RESET = CNT_W'(LANES);
    localparam logic [BETA_W-1:0] TRIM_BETA_RESET    = '0;

    // Divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS = 4;
    localparam int REM_W     = CNT_W - 1;

    typedef enum logic {
        REG_CLIENT_COUNT = 1'b0,
        REG_TRIM_BETA    = 1'b1
    } t_reg_idx;

    // Sideband that travels with each item through the pipeline
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] kept;
    } t_ctl;

endpackage

/* hw/rtl/ctm_lane.sv */
// One client lane: ranks its value against the other valid lanes and keeps or drops it.
// Depends on ctm_pkg.
`timescale 1ns / 1ps

module ctm_lane #(
    parameter int VALUE_WIDTH = 32,
    parameter int SUM_W       = 35,
    parameter int LANE_IDX    = 0
) (
    input  logic                                           i_clk,
    input  logic [ctm_pkg::LANES-1:0][VALUE_WIDTH-1:0]     i_values,
    input  logic [ctm_pkg::CNT_W-1:0]                      i_n,
    input  logic [ctm_pkg::CNT_W-1:0]                      i_lo,
    input  logic [ctm_pkg::CNT_W-1:0]                      i_hi,
    output logic [SUM_W-1:0]                               o_term
);
    import ctm_pkg::*;

    logic [LANE_W-1:0] w_rank;
    logic              w_keep;
    logic [SUM_W-1:0]  n_term;

    // Count valid lanes that sort ahead of this one; ties go by lane order
    always_comb begin
        w_rank = '0;
        for (int j = 0; j < LANES; j++) begin
            if (j != LANE_IDX && CNT_W'(j) < i_n) begin
                if (($signed(i_values[j]) < $signed(i_values[LANE_IDX])) ||
                    (i_values[j] == i_values[LANE_IDX] && j < LANE_IDX)) begin
                    w_rank = w_rank + LANE_W'(1);
                end
            end
        end
    end

    // Keep the value when its sorted position falls inside the kept window
    always_comb begin
        w_keep = (CNT_W'(LANE_IDX) < i_n) &&
                 (CNT_W'(w_rank) >= i_lo) && (CNT_W'(w_rank) < i_hi);
        n_term = w_keep ? SUM_W'($signed(i_values[LANE_IDX])) : '0;
    end

    always_ff @(posedge i_clk) begin
        o_term <= n_term;
    end

endmodule

/* hw/rtl/ctm_merge.sv */
// Merging stage: registered adder tree over the lane terms, then sign and magnitude.
// Depends on ctm_pkg.
`timescale 1ns / 1ps

module ctm_merge #(
    parameter int SUM_W = 35
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [ctm_pkg::LANES-1:0][SUM_W-1:0]     i_terms,
    input  ctm_pkg::t_ctl                            i_ctl,
    output logic [SUM_W-1:0]                         o_mag,
    output logic                                     o_neg,
    output ctm_pkg::t_ctl                            o_ctl
);
    import ctm_pkg::*;

    // Heap-ordered tree nodes: node i sums nodes 2i and 2i+1, leaves are the lane terms
    logic [SUM_W-1:0] r_node [1:LANES-1];
    t_ctl             r_ctl  [0:LANE_W];
    logic [SUM_W-1:0] r_mag;
    logic             r_neg;

    for (genvar i = 1; i < LANES; i++) begin : g_node
        logic [SUM_W-1:0] w_left;
        logic [SUM_W-1:0] w_right;
        if (2 * i < LANES) begin : g_inner
            assign w_left  = r_node[2*i];
            assign w_right = r_node[2*i+1];
        end else begin : g_leaf
            assign w_left  = i_terms[2*i-LANES];
            assign w_right = i_terms[2*i+1-LANES];
        end
        always_ff @(posedge i_clk) begin
            r_node[i] <= w_left + w_right;
        end
    end

    // Take sign and magnitude of the root sum
    always_ff @(posedge i_clk) begin
        r_neg <= r_node[1][SUM_W-1];
        r_mag <= r_node[1][SUM_W-1] ? (SUM_W'(0) - r_node[1]) : r_node[1];
    end

    // Advance the sideband in step with the tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LANE_W; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k <= LANE_W; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;
    assign o_ctl = r_ctl[LANE_W];

endmodule

/* hw/rtl/ctm_div_stage.sv */
// One divider stage: resolves DIV_STEPS quotient bits of magnitude / kept count.
// Depends on ctm_pkg.
`timescale 1ns / 1ps

module ctm_div_stage #(
    parameter int PAD_W = 36
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [PAD_W-1:0]              i_x,
    input  logic [ctm_pkg::REM_W-1:0]     i_rem,
    input  logic                          i_neg,
    input  ctm_pkg::t_ctl                 i_ctl,
    output logic [PAD_W-1:0]              o_x,
    output logic [ctm_pkg::REM_W-1:0]     o_rem,
    output logic                          o_neg,
    output ctm_pkg::t_ctl                 o_ctl
);
    import ctm_pkg::*;

    logic [PAD_W-1:0] n_x;
    logic [REM_W-1:0] n_rem;
    logic [CNT_W-1:0] w_trial;
    logic             w_qbit;

    // Shift dividend bits out of the top, quotient bits in at the bottom
    always_comb begin
        n_x     = i_x;
        n_rem   = i_rem;
        w_trial = '0;
        w_qbit  = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            w_trial = {n_rem, n_x[PAD_W-1]};
            w_qbit  = (w_trial >= i_ctl.kept);
            n_x     = {n_x[PAD_W-2:0], w_qbit};
            n_rem   = w_qbit ? REM_W'(w_trial - i_ctl.kept) : w_trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_x   <= n_x;
        o_rem <= n_rem;
        o_neg <= i_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

endmodule

/* hw/rtl/coordinate_trimmed_mean_core.sv */
// Coordinate-wise trimmed mean over up to eight client lanes.
// Depends on ctm_pkg, ctm_lane, ctm_merge, ctm_div_stage.
//
// Usage:
//   Input: drive i_value_0..i_value_7 (signed Q16.16, one per client) and
//   pulse start; an item is taken on every edge where start is high and busy
//   is low. busy stays low, so a new item may enter on every clock cycle.
//   Output: o_valid is high for exactly one cycle per item, with
//   o_trimmed_mean (signed, truncated toward zero) and o_kept_count. The
//   receiver cannot stall; results appear in input order.
//   Pipeline: one capture stage, one lane ranking stage, three adder-tree
//   levels, one magnitude stage, the divider stages at four quotient bits
//   each, and the output register.
//   Throughput: one item per cycle; every lane ranks its value in parallel.
//   Configuration: APB-style writes to client_count (address 0) and
//   trim_beta (address 4); the user must write only while no item is in flight, as the block does not enforce it.
//   Reset: synchronous, active low; clears the pipeline valids and loads
//   client_count = 8, trim_beta = 0.
`timescale 1ns / 1ps

module coordinate_trimmed_mean_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_0,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_1,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_2,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_3,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_4,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_5,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_6,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_7,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ctm_pkg::ADDR_W-1:0]           paddr,
    input  logic [ctm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ctm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    output logic                                 o_valid,
    output logic signed [VALUE_WIDTH-1:0]        o_trimmed_mean,
    output logic [ctm_pkg::CNT_W-1:0]            o_kept_count
);
    import ctm_pkg::*;

    localparam int SUM_W      = VALUE_WIDTH + LANE_W;
    localparam int DIV_STAGES = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W      = DIV_STAGES * DIV_STEPS;
    localparam int PROD_W     = BETA_W + CNT_W;

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0]  r_client_count;
    logic [BETA_W-1:0] r_trim_beta;
    t_reg_idx          w_reg_idx;
    logic              w_cfg_write;

    assign pready      = 1'b1;
    assign busy        = 1'b0;
    assign w_reg_idx   = t_reg_idx'(paddr[REG_IDX_LSB]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    // Write on the access cycle of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_count <= CLIENT_COUNT_RESET;
            r_trim_beta    <= TRIM_BETA_RESET;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                REG_CLIENT_COUNT: r_client_count <= pwdata[CNT_W-1:0];
                REG_TRIM_BETA:    r_trim_beta    <= pwdata[BETA_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_reg_idx)
            REG_CLIENT_COUNT: prdata = APB_DATA_W'(r_client_count);
            REG_TRIM_BETA:    prdata = APB_DATA_W'(r_trim_beta);
            default:          prdata = '0;
        endcase
    end

    // ---------------- trim window from the registers ----------------
    logic [CNT_W-1:0]  w_n;
    logic [BETA_W-1:0] w_beta;
    logic [PROD_W-1:0] w_prod;
    logic [CNT_W-1:0]  w_t;
    logic              w_keep_all;
    logic [CNT_W-1:0]  n_s0_lo;
    logic [CNT_W-1:0]  n_s0_hi;

    always_comb begin
        // Clamp client count to 1..LANES and beta to one
        if (r_client_count == '0) begin
            w_n = CNT_W'(1);
        end else if (r_client_count > CNT_W'(LANES)) begin
            w_n = CNT_W'(LANES);
        end else begin
            w_n = r_client_count;
        end
        w_beta = (r_trim_beta > BETA_ONE) ? BETA_ONE : r_trim_beta;

        // Per-side trim count, floor(beta * n)
        w_prod = PROD_W'(w_beta) * PROD_W'(w_n);
        w_t    = w_prod[BETA_FRAC +: CNT_W];

        // Keep everything when trimming would leave nothing
        w_keep_all = ({w_t, 1'b0} >= {1'b0, w_n});
        n_s0_lo    = w_keep_all ? '0  : w_t;
        n_s0_hi    = w_keep_all ? w_n : (w_n - w_t);
    end

    // ---------------- capture stage ----------------
    logic [LANES-1:0][VALUE_WIDTH-1:0] r_s0_vals;
    logic [CNT_W-1:0]                  r_s0_n;
    logic [CNT_W-1:0]                  r_s0_lo;
    logic [CNT_W-1:0]                  r_s0_hi;
    t_ctl                              r_s0_ctl;
    t_ctl                              r_s1_ctl;

    always_ff @(posedge i_clk) begin
        r_s0_vals[0] <= i_value_0;
        r_s0_vals[1] <= i_value_1;
        r_s0_vals[2] <= i_value_2;
        r_s0_vals[3] <= i_value_3;
        r_s0_vals[4] <= i_value_4;
        r_s0_vals[5] <= i_value_5;
        r_s0_vals[6] <= i_value_6;
        r_s0_vals[7] <= i_value_7;
        r_s0_n       <= w_n;
        r_s0_lo      <= n_s0_lo;
        r_s0_hi      <= n_s0_hi;
    end

    // Hold valid and kept count alongside the capture and lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
            r_s1_ctl <= '0;
        end else begin
            r_s0_ctl.valid <= start && !busy;
            r_s0_ctl.kept  <= n_s0_hi - n_s0_lo;
            r_s1_ctl       <= r_s0_ctl;
        end
    end

    // ---------------- parallel lanes ----------------
    logic [LANES-1:0][SUM_W-1:0] w_terms;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        ctm_lane #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .SUM_W       (SUM_W),
            .LANE_IDX    (k)
        ) u_lane (
            .i_clk    (i_clk),
            .i_values (r_s0_vals),
            .i_n      (r_s0_n),
            .i_lo     (r_s0_lo),
            .i_hi     (r_s0_hi),
            .o_term   (w_terms[k])
        );
    end

    // ---------------- merge ----------------
    logic [SUM_W-1:0] w_mag;
    logic             w_neg;
    t_ctl             w_merge_ctl;

    ctm_merge #(
        .SUM_W (SUM_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_terms (w_terms),
        .i_ctl   (r_s1_ctl),
        .o_mag   (w_mag),
        .o_neg   (w_neg),
        .o_ctl   (w_merge_ctl)
    );

    // ---------------- divider pipeline ----------------
    logic [PAD_W-1:0] w_div_x   [0:DIV_STAGES];
    logic [REM_W-1:0] w_div_rem [0:DIV_STAGES];
    logic             w_div_neg [0:DIV_STAGES];
    t_ctl             w_div_ctl [0:DIV_STAGES];

    assign w_div_x[0]   = PAD_W'(w_mag);
    assign w_div_rem[0] = '0;
    assign w_div_neg[0] = w_neg;
    assign w_div_ctl[0] = w_merge_ctl;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        ctm_div_stage #(
            .PAD_W (PAD_W)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_x     (w_div_x[s]),
            .i_rem   (w_div_rem[s]),
            .i_neg   (w_div_neg[s]),
            .i_ctl   (w_div_ctl[s]),
            .o_x     (w_div_x[s+1]),
            .o_rem   (w_div_rem[s+1]),
            .o_neg   (w_div_neg[s+1]),
            .o_ctl   (w_div_ctl[s+1])
        );
    end

    // ---------------- output register ----------------
    logic [PAD_W-1:0] w_quot;

    // Restore the sign; the remainder is dropped, which truncates toward zero
    assign w_quot = w_div_neg[DIV_STAGES] ? (PAD_W'(0) - w_div_x[DIV_STAGES])
                                          : w_div_x[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        o_trimmed_mean <= w_quot[VALUE_WIDTH-1:0];
        o_kept_count   <= w_div_ctl[DIV_STAGES].kept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_div_ctl[DIV_STAGES].valid;
        end
    end

endmodule

/* verif/coordinate_trimmed_mean_core_checker.sv */
// Checker for the coordinate trimmed-mean core: tracks register writes,
// predicts each item's trimmed mean and compares results in order.
// Depends on ctm_pkg.
`timescale 1ns / 1ps

module coordinate_trimmed_mean_core_checker #(
    parameter int VW = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic                                    i_busy,
    input  logic [ctm_pkg::LANES-1:0][VW-1:0]       i_lane_values,
    input  logic                                    i_psel,
    input  logic                                    i_penable,
    input  logic                                    i_pwrite,
    input  logic [ctm_pkg::ADDR_W-1:0]              i_paddr,
    input  logic [ctm_pkg::APB_DATA_W-1:0]          i_pwdata,
    input  logic                                    i_pready,
    input  logic                                    i_valid,
    input  logic signed [VW-1:0]                    i_trimmed_mean,
    input  logic [ctm_pkg::CNT_W-1:0]               i_kept_count,
    output int                                      o_pending,
    output int                                      o_fail_count
);
    import ctm_pkg::*;

    typedef struct packed {
        logic signed [VW-1:0] mean;
        logic [CNT_W-1:0]     kept;
    } t_mean_result;

    t_mean_result     expected_means[$];
    logic [CNT_W-1:0] client_count_q;
    logic [BETA_W-1:0] trim_beta_q;

    // Sort the active lanes, trim both tails, average what is left
    function automatic t_mean_result predict_result(
        input logic [LANES-1:0][VW-1:0] vals,
        input logic [CNT_W-1:0]         count_reg,
        input logic [BETA_W-1:0]        beta_reg
    );
        longint       lane [LANES];
        longint       key;
        longint       acc;
        int           n;
        int           beta;
        int           trim;
        int           lo;
        int           hi;
        int           j;
        t_mean_result res;

        n = int'(count_reg);
        if (n == 0) n = 1;
        if (n > LANES) n = LANES;
        beta = int'(beta_reg);
        if (beta > int'(BETA_ONE)) beta = int'(BETA_ONE);

        // Insertion sort over the first n lanes
        for (int i = 0; i < n; i++) begin
            key = longint'($signed(vals[i]));
            j = i;
            while (j > 0 && lane[j-1] > key) begin
                lane[j] = lane[j-1];
                j--;
            end
            lane[j] = key;
        end

        trim = (beta * n) / int'(BETA_ONE);
        lo = trim;
        hi = (n > trim) ? n - trim : n;
        // Keep everything when trimming would empty the set
        if (lo >= hi) begin
            lo = 0;
            hi = n;
        end

        acc = 0;
        for (int i = lo; i < hi; i++) acc += lane[i];
        res.mean = VW'(acc / longint'(hi - lo));
        res.kept = CNT_W'(hi - lo);
        return res;
    endfunction

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_mean_result want;

        if (!i_rst_n) begin
            client_count_q <= CLIENT_COUNT_RESET;
            trim_beta_q    <= TRIM_BETA_RESET;
            expected_means.delete();
            o_pending      <= 0;
        end else begin
            // Compare each result transfer with the oldest prediction
            if (i_valid) begin
                if (expected_means.size() == 0) begin
                    $error("unexpected result: mean=%0d kept_count=%0d",
                           i_trimmed_mean, i_kept_count);
                    o_fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (i_trimmed_mean !== want.mean) begin
                        $error("mean: expected %0d, got %0d",
                               want.mean, i_trimmed_mean);
                        o_fail_count++;
                    end
                    if (i_kept_count !== want.kept) begin
                        $error("kept_count: expected %0d, got %0d",
                               want.kept, i_kept_count);
                        o_fail_count++;
                    end
                end
            end

            // Predict on every accepted input transfer
            if (i_start && !i_busy)
                expected_means = {expected_means,
                    predict_result(i_lane_values, client_count_q, trim_beta_q)};

            // Mirror register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[REG_IDX_LSB]))
                    REG_CLIENT_COUNT: client_count_q <= i_pwdata[CNT_W-1:0];
                    REG_TRIM_BETA:    trim_beta_q    <= i_pwdata[BETA_W-1:0];
                    default:          ;
                endcase
            end

            o_pending <= expected_means.size();
        end
    end

endmodule

/* verif/coordinate_trimmed_mean_core_tb.sv */
// Testbench top for the coordinate trimmed-mean core: directed and random
// items over a sweep of client counts and trim fractions.
// Depends on ctm_pkg, coordinate_trimmed_mean_core and its checker.
`timescale 1ns / 1ps

module coordinate_trimmed_mean_core_tb;
    import ctm_pkg::*;

    localparam int VW              = 32;
    localparam int ITEMS_PER_PHASE = 118;
    localparam int NUM_PHASES      = 16;
    localparam int DRAIN_CYCLES    = 30;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [LANES-1:0][VW-1:0]  lane_values;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      o_valid;
    logic signed [VW-1:0]      o_trimmed_mean;
    logic [CNT_W-1:0]          o_kept_count;
    int                        pending;
    int                        fail_count;
    int                        burst_left;

    // Client count and trim fraction per phase, extremes first
    int phase_count [NUM_PHASES] = '{1, 0, 15, 9, 8, 2, 2, 3, 4, 5, 6, 7, 8, 8, 0, 0};
    int phase_beta  [NUM_PHASES] = '{0, 77, 511, 257, 256, 128, 127, 86, 64, 103, 43,
                                     37, 32, 96, 0, 0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    coordinate_trimmed_mean_core #(
        .VALUE_WIDTH (VW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value_0      (lane_values[0]),
        .i_value_1      (lane_values[1]),
        .i_value_2      (lane_values[2]),
        .i_value_3      (lane_values[3]),
        .i_value_4      (lane_values[4]),
        .i_value_5      (lane_values[5]),
        .i_value_6      (lane_values[6]),
        .i_value_7      (lane_values[7]),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_valid        (o_valid),
        .o_trimmed_mean (o_trimmed_mean),
        .o_kept_count   (o_kept_count)
    );

    coordinate_trimmed_mean_core_checker #(
        .VW (VW)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_lane_values  (lane_values),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .i_valid        (o_valid),
        .i_trimmed_mean (o_trimmed_mean),
        .i_kept_count   (o_kept_count),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // Pick one lane value; mix of full range, small fixed-point, ties, extremes
    function automatic logic [VW-1:0] lane_value(input int mode);
        logic [VW-1:0] v;
        case (mode)
            0, 1, 2: v = VW'($urandom);
            3, 4:    v = VW'($signed($urandom_range(0, 32)) - 16) << 16
                         | VW'($urandom_range(0, 3) << 14);
            5, 6:    v = VW'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b0, {(VW-1){1'b1}}};
                    1:       v = {1'b1, {(VW-1){1'b0}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = VW'(1);
                endcase
            end
        endcase
        return v;
    endfunction

    // Hold one item on the inputs until the core takes it; sometimes idle between bursts
    task automatic send_item(input logic [LANES-1:0][VW-1:0] vals);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
        lane_values <= vals;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    // Drop start and wait until every result has come back
    task automatic drain;
        start      <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Register write with a setup and an access phase, junk in the unused upper data bits
    task automatic reg_write(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << REG_IDX_LSB;
        pwdata  <= {APB_DATA_W'($urandom) << 12} | APB_DATA_W'(value & 12'hFFF)
                   & ~(APB_DATA_W'(12'hFFF) & ~APB_DATA_W'(idx == REG_CLIENT_COUNT
                                                            ? 'hF : 'h1FF));
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Leave the bus idle between transfers
        @(posedge i_clk);
    endtask

    initial begin
        logic [LANES-1:0][VW-1:0] vals;
        int                       mode;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        lane_values <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        burst_left  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset settings: extremes, wide sums, truncation
        for (int d = 0; d < 12; d++) begin
            for (int k = 0; k < LANES; k++) begin
                case (d)
                    0:  vals[k] = {1'b0, {(VW-1){1'b1}}};
                    1:  vals[k] = {1'b1, {(VW-1){1'b0}}};
                    2:  vals[k] = '0;
                    3:  vals[k] = k[0] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
                    4:  vals[k] = VW'(k) << 16;
                    5:  vals[k] = VW'(-k) << 16;
                    6:  vals[k] = (k == 3) ? {1'b0, {(VW-1){1'b1}}} : VW'(k);
                    7:  vals[k] = '1;
                    8:  vals[k] = (k == 0) ? VW'(-15) : '0;
                    9:  vals[k] = (k == 7) ? VW'(15) : '0;
                    10: vals[k] = (k == 5) ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
                    default: vals[k] = VW'(32'h5555_AAAA) ^ {VW{k[0]}};
                endcase
            end
            send_item(vals);
        end
        drain();

        // Random phases over a sweep of register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= NUM_PHASES - 2) begin
                phase_count[p] = $urandom_range(0, 15);
                phase_beta[p]  = $urandom_range(0, 511);
            end
            reg_write(REG_CLIENT_COUNT, phase_count[p]);
            reg_write(REG_TRIM_BETA, phase_beta[p]);
            for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
                mode = $urandom_range(0, 9);
                for (int k = 0; k < LANES; k++)
                    vals[k] = lane_value(mode >= 8 ? $urandom_range(0, 9) : mode);
                send_item(vals);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("coordinate_trimmed_mean_core_tb passed");
        end else begin
            $display("coordinate_trimmed_mean_core_tb failed");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("coordinate_trimmed_mean_core_tb failed");
        $finish;
    end

endmodule
